// File: sv/topk_smallest_selector_unit_assert.svh
`ifndef TOPK_SMALLEST_SELECTOR_UNIT_ASSERT_SVH
`define TOPK_SMALLEST_SELECTOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TSU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/tsu_pkg.sv
`timescale 1ns / 1ps

package tsu_pkg;

  localparam int SCORE_W   = 32;
  localparam int ID_W      = 31;
  localparam int RANK_W    = 4;
  localparam int COUNT_W   = 5;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam int MAX_K_DEF = 16;

  localparam logic [COUNT_W-1:0] RESULT_COUNT_RST  = COUNT_W'(16);
  localparam logic [ADDR_W-1:0]  ADDR_RESULT_COUNT = ADDR_W'(0);

  typedef struct packed {
    logic                      valid;
    logic signed [SCORE_W-1:0] score;
    logic [ID_W-1:0]           id;
  } pair_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_SHIFT,
    CMD_CLEAR
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

endpackage

// File: sv/tsu_cell.sv
`timescale 1ns / 1ps

module tsu_cell (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tsu_pkg::cmd_t                      cmd,
  input  logic signed [tsu_pkg::SCORE_W-1:0] new_score,
  input  logic [tsu_pkg::ID_W-1:0]           new_id,
  input  tsu_pkg::pair_t                     left,
  input  logic                               left_keep,
  input  tsu_pkg::pair_t                     right,
  output tsu_pkg::pair_t                     own,
  output logic                               keep
);

  logic                               valid_r, valid_nxt;
  logic signed [tsu_pkg::SCORE_W-1:0] score_r, score_nxt;
  logic [tsu_pkg::ID_W-1:0]           id_r, id_nxt;

  assign keep = valid_r && ((score_r < new_score) ||
                            ((score_r == new_score) && (id_r <= new_id)));

  always_comb begin
    valid_nxt = valid_r;
    score_nxt = score_r;
    id_nxt    = id_r;
    unique case (cmd)
      tsu_pkg::CMD_HOLD: begin
      end
      tsu_pkg::CMD_INSERT: begin
        if (!keep) begin
          if (left_keep) begin
            valid_nxt = 1'b1;
            score_nxt = new_score;
            id_nxt    = new_id;
          end else begin
            valid_nxt = left.valid;
            score_nxt = left.score;
            id_nxt    = left.id;
          end
        end
      end
      tsu_pkg::CMD_SHIFT: begin
        valid_nxt = right.valid;
        score_nxt = right.score;
        id_nxt    = right.id;
      end
      tsu_pkg::CMD_CLEAR: begin
        valid_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    score_r <= score_nxt;
    id_r    <= id_nxt;
  end

  assign own.valid = valid_r;
  assign own.score = score_r;
  assign own.id    = id_r;

endmodule

// File: sv/topk_smallest_selector_unit.sv
`timescale 1ns / 1ps

// Channel   | Handshake                        | Payload
// input     | start, busy                      | in_score, in_cand_id, in_last_candidate
// result    | out_valid                        | out_score, out_id, out_rank, out_last_result
// config    | psel, penable, pwrite, pready    | paddr, pwdata, prdata
//
// A word is inserted into the cell row in the cycle it is accepted, one per cycle while busy is low.
// After the last word of a list, busy stays high while 1 to MAX_K results are emitted
// and the row shifts toward cell 0; results are registered, appearing in the next cycle.
// Synchronous active-low reset empties the row and sets result_count to 16.
// Results are shown for one cycle each and cannot be stalled.

module topk_smallest_selector_unit #(
  parameter int MAX_K = tsu_pkg::MAX_K_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [tsu_pkg::SCORE_W-1:0] in_score,
  input  logic [tsu_pkg::ID_W-1:0]           in_cand_id,
  input  logic                               in_last_candidate,
  output logic                               out_valid,
  output logic signed [tsu_pkg::SCORE_W-1:0] out_score,
  output logic [tsu_pkg::ID_W-1:0]           out_id,
  output logic [tsu_pkg::RANK_W-1:0]         out_rank,
  output logic                               out_last_result,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tsu_pkg::ADDR_W-1:0]         paddr,
  input  logic [tsu_pkg::DATA_W-1:0]         pwdata,
  output logic [tsu_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);

  localparam int LW = $clog2(MAX_K + 1);

  tsu_pkg::state_t state_r, state_nxt;
  tsu_pkg::cmd_t   cmd;
  tsu_pkg::pair_t  cell_q [MAX_K];
  logic [MAX_K-1:0] keep_v;
  logic [MAX_K:0]   valid_ext;

  logic [tsu_pkg::COUNT_W-1:0] result_count_r;
  logic [LW-1:0]               idx_r, idx_nxt;
  logic [7:0]                  rc_ext, lim8;
  logic                        accept, emit_last, cfg_write;

  logic                               out_valid_r;
  logic signed [tsu_pkg::SCORE_W-1:0] out_score_r;
  logic [tsu_pkg::ID_W-1:0]           out_id_r;
  logic [tsu_pkg::RANK_W-1:0]         out_rank_r;
  logic                               out_last_r;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr == tsu_pkg::ADDR_RESULT_COUNT);
  assign prdata    = (paddr == tsu_pkg::ADDR_RESULT_COUNT) ?
                     tsu_pkg::DATA_W'(result_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      result_count_r <= tsu_pkg::RESULT_COUNT_RST;
    end else if (cfg_write) begin
      result_count_r <= pwdata[tsu_pkg::COUNT_W-1:0];
    end
  end

  // Cell row.
  genvar g;
  generate
    for (g = 0; g < MAX_K; g++) begin : g_cell
      tsu_pkg::pair_t left_pair, right_pair;
      logic           left_keep;
      if (g == 0) begin : g_head
        assign left_pair = '0;
        assign left_keep = 1'b1;
      end else begin : g_body
        assign left_pair = cell_q[g-1];
        assign left_keep = keep_v[g-1];
      end
      if (g == MAX_K - 1) begin : g_tail
        assign right_pair = '0;
      end else begin : g_mid
        assign right_pair = cell_q[g+1];
      end
      tsu_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .new_score (in_score),
        .new_id    (in_cand_id),
        .left      (left_pair),
        .left_keep (left_keep),
        .right     (right_pair),
        .own       (cell_q[g]),
        .keep      (keep_v[g])
      );
      assign valid_ext[g] = cell_q[g].valid;
    end
  endgenerate
  assign valid_ext[MAX_K] = 1'b0;

  // Emission limit, clamped to 1..MAX_K.
  assign rc_ext = 8'(result_count_r);
  assign lim8   = (rc_ext == 8'd0) ? 8'd1 :
                  ((rc_ext > 8'(MAX_K)) ? 8'(MAX_K) : rc_ext);

  assign accept    = start && !busy;
  assign emit_last = ((8'(idx_r) + 8'd1) == lim8) || !valid_ext[1];
  assign busy      = (state_r == tsu_pkg::ST_EMIT);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tsu_pkg::ST_IDLE: if (accept && in_last_candidate) state_nxt = tsu_pkg::ST_EMIT;
      tsu_pkg::ST_EMIT: if (emit_last) state_nxt = tsu_pkg::ST_IDLE;
      default:          state_nxt = tsu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd     = tsu_pkg::CMD_HOLD;
    idx_nxt = '0;
    unique case (state_r)
      tsu_pkg::ST_IDLE: begin
        if (accept) cmd = tsu_pkg::CMD_INSERT;
      end
      tsu_pkg::ST_EMIT: begin
        cmd     = emit_last ? tsu_pkg::CMD_CLEAR : tsu_pkg::CMD_SHIFT;
        idx_nxt = emit_last ? '0 : LW'(idx_r + 1'b1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tsu_pkg::ST_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= busy;
    end
  end

  always_ff @(posedge clk) begin
    out_score_r <= cell_q[0].score;
    out_id_r    <= cell_q[0].id;
    out_rank_r  <= tsu_pkg::RANK_W'(idx_r);
    out_last_r  <= emit_last;
  end

  assign out_valid       = out_valid_r;
  assign out_score       = out_score_r;
  assign out_id          = out_id_r;
  assign out_rank        = out_rank_r;
  assign out_last_result = out_last_r;

endmodule

// File: sv/tsu_checker.sv
`timescale 1ns / 1ps
`include "topk_smallest_selector_unit_assert.svh"

module tsu_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         in_last_candidate,
  input logic                         out_valid,
  input logic [tsu_pkg::RANK_W-1:0]   out_rank,
  input logic                         out_last_result
);

  `TSU_ASSERT_NEXT(a_last_word_busy, start && !busy && in_last_candidate, busy, "no emission after last word")
  `TSU_ASSERT_NOW(a_mid_result_busy, out_valid && !out_last_result, busy, "emission ended early")
  `TSU_ASSERT_NEXT(a_idle_no_result, !busy, !out_valid, "result without emission")
  `TSU_ASSERT_NEXT(a_rank_step, out_valid && !out_last_result, out_valid && (out_rank == tsu_pkg::RANK_W'($past(out_rank) + 1'b1)), "rank sequence broken")
  `TSU_ASSERT_NEXT(a_gap_after_last, out_valid && out_last_result, !out_valid, "result after final result")

endmodule

bind topk_smallest_selector_unit tsu_checker u_tsu_checker (.*);

// File: tb/topk_smallest_selector_unit_tb.sv
`timescale 1ns / 1ps

module topk_smallest_selector_unit_tb;
  import tsu_pkg::*;

  localparam int MAX_K = MAX_K_DEF;
  localparam logic [ADDR_W-1:0] ADDR_UNMAPPED = ADDR_W'(4);
  localparam int PHASES = 9;
  localparam int WORDS_PER_PHASE = 34;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [ID_W-1:0]           id;
    logic [RANK_W-1:0]         rank;
    logic                      last;
  } ranked_pair_t;

  class topk_tracker;
    logic signed [SCORE_W-1:0] kept_score [MAX_K];
    logic [ID_W-1:0]           kept_id [MAX_K];
    int                        kept_num;
    logic [COUNT_W-1:0]        result_count;
    ranked_pair_t              ranked_q[$];
    int                        errors;

    function new();
      kept_num = 0;
      result_count = RESULT_COUNT_RST;
      errors = 0;
    endfunction

    function void write_reg(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
      if (addr == ADDR_RESULT_COUNT) begin
        result_count = data[COUNT_W-1:0];
      end
    endfunction

    function void add_candidate(logic signed [SCORE_W-1:0] s, logic [ID_W-1:0] id,
                                logic last);
      int pos;
      int limit;
      int n;
      int i;
      ranked_pair_t r;
      pos = 0;
      while (pos < kept_num &&
             (kept_score[pos] < s || (kept_score[pos] == s && kept_id[pos] <= id))) begin
        pos++;
      end
      if (pos < MAX_K) begin
        for (i = MAX_K - 1; i > pos; i--) begin
          kept_score[i] = kept_score[i-1];
          kept_id[i] = kept_id[i-1];
        end
        kept_score[pos] = s;
        kept_id[pos] = id;
        if (kept_num < MAX_K) begin
          kept_num++;
        end
      end
      if (!last) begin
        return;
      end
      if (result_count == 0) begin
        limit = 1;
      end else if (int'(result_count) > MAX_K) begin
        limit = MAX_K;
      end else begin
        limit = int'(result_count);
      end
      n = (kept_num < limit) ? kept_num : limit;
      for (i = 0; i < n; i++) begin
        r.score = kept_score[i];
        r.id = kept_id[i];
        r.rank = RANK_W'(i);
        r.last = (i == n - 1);
        ranked_q = {ranked_q, r};
      end
      kept_num = 0;
    endfunction

    function void mismatch(string field, logic [SCORE_W-1:0] want, logic [SCORE_W-1:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endfunction

    function void check_result(logic signed [SCORE_W-1:0] s, logic [ID_W-1:0] id,
                               logic [RANK_W-1:0] rank, logic last);
      ranked_pair_t want;
      if (ranked_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, actual score %h id %h",
                 $time, s, id);
        return;
      end
      want = ranked_q.pop_front();
      if (s !== want.score) mismatch("out_score", want.score, s);
      if (id !== want.id) mismatch("out_id", want.id, id);
      if (rank !== want.rank) mismatch("out_rank", want.rank, rank);
      if (last !== want.last) mismatch("out_last_result", want.last, last);
    endfunction

    function int pending();
      return ranked_q.size();
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic signed [SCORE_W-1:0] in_score = '0;
  logic [ID_W-1:0]           in_cand_id = '0;
  logic                      in_last_candidate = 1'b0;
  logic                      out_valid;
  logic signed [SCORE_W-1:0] out_score;
  logic [ID_W-1:0]           out_id;
  logic [RANK_W-1:0]         out_rank;
  logic                      out_last_result;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [ADDR_W-1:0]         paddr = '0;
  logic [DATA_W-1:0]         pwdata = '0;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;

  topk_tracker tracker = new();

  topk_smallest_selector_unit u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_score(in_score),
    .in_cand_id(in_cand_id),
    .in_last_candidate(in_last_candidate),
    .out_valid(out_valid),
    .out_score(out_score),
    .out_id(out_id),
    .out_rank(out_rank),
    .out_last_result(out_last_result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        tracker.check_result(out_score, out_id, out_rank, out_last_result);
      end
      if (start && !busy) begin
        tracker.add_candidate(in_score, in_cand_id, in_last_candidate);
      end
    end
  end

  task automatic send_word(input logic signed [SCORE_W-1:0] s, input logic [ID_W-1:0] id,
                           input logic last, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_score <= s;
    in_cand_id <= id;
    in_last_candidate <= last;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (MAX_K + 4) @(posedge clk);
  endtask

  task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tracker.write_reg(addr, data);
  endtask

  task automatic check_count_reg();
    logic [DATA_W-1:0] want;
    want = DATA_W'(tracker.result_count);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_RESULT_COUNT;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) tracker.mismatch("prdata", want, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic signed [SCORE_W-1:0] pick_score();
    case ($urandom_range(0, 9))
      0: return ($urandom_range(0, 1) == 1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      1, 2, 3: return SCORE_W'($signed($urandom_range(0, 7)) - 4);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    case ($urandom_range(0, 9))
      0, 1, 2: return ID_W'($urandom_range(0, 3));
      3: return ($urandom_range(0, 1) == 1) ? {ID_W{1'b1}} : '0;
      default: return ID_W'($urandom);
    endcase
  endfunction

  task automatic send_list(input int len, input bit burst, inout int sent);
    logic signed [SCORE_W-1:0] s;
    logic [ID_W-1:0] id;
    int k;
    int gap;
    for (k = 0; k < len; k++) begin
      // An occasional repeat of the previous word yields identical pairs.
      if (k == 0 || $urandom_range(0, 9) != 0) begin
        s = pick_score();
        id = pick_id();
      end
      gap = burst ? 0 : $urandom_range(0, 16);
      send_word(s, id, k == len - 1, gap);
      sent++;
    end
  endtask

  initial begin
    int phase;
    int sent;
    int len;
    int k;
    logic [COUNT_W-1:0] count_val;
    logic [DATA_W-1:0] data;
    sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    check_count_reg();

    send_word(32'sh8000_0000, '0, 1'b1, 0);
    send_word(32'sh7FFF_FFFF, {ID_W{1'b1}}, 1'b0, $urandom_range(0, 16));
    send_word(32'sh0005_0000, ID_W'(9), 1'b0, $urandom_range(0, 16));
    send_word(32'sh0005_0000, ID_W'(3), 1'b0, $urandom_range(0, 16));
    send_word(32'sh0005_0000, ID_W'(3), 1'b0, $urandom_range(0, 16));
    send_word(-32'sd1, {ID_W{1'b1}}, 1'b0, $urandom_range(0, 16));
    send_word('0, '0, 1'b1, $urandom_range(0, 16));
    // A full row, then a word that sorts past its end and is dropped.
    for (k = 0; k < MAX_K; k++) begin
      send_word(SCORE_W'(1000 - k * 7), ID_W'(k), 1'b0, 0);
    end
    send_word(32'sh7FFF_FFFF, ID_W'(5), 1'b0, 0);
    send_word(-32'sd5, ID_W'(1), 1'b1, 0);
    wait_drained();

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: count_val = COUNT_W'(0);
        1: count_val = COUNT_W'(17);
        2: count_val = COUNT_W'(31);
        3: count_val = COUNT_W'(1);
        4: count_val = COUNT_W'(16);
        5: count_val = COUNT_W'(2);
        default: count_val = COUNT_W'($urandom_range(0, 31));
      endcase
      data = $urandom;
      data[COUNT_W-1:0] = count_val;
      reg_write(ADDR_RESULT_COUNT, data);
      check_count_reg();
      if (phase == 3) begin
        reg_write(ADDR_UNMAPPED, $urandom);
        check_count_reg();
      end
      len = 0;
      while (len < WORDS_PER_PHASE) begin
        k = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 24) : $urandom_range(1, 12);
        send_list(k, $urandom_range(0, 3) == 0, sent);
        len += k;
        if ($urandom_range(0, 5) == 0) wait_drained();
      end
      wait_drained();
    end

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
